[sv/bfdh_pkg.sv]
// Shared types, sizes and codes for the FNV double-hash Bloom filter.
// No dependencies; every other file imports this package.
package bfdh_pkg;

  // Filter store geometry
  localparam int FILTER_BITS = 65536;
  localparam int IDX_W       = $clog2(FILTER_BITS);
  localparam int SIZE_W      = IDX_W + 1;
  localparam int ROW_W       = 32;
  localparam int ROW_BITS    = $clog2(ROW_W);
  localparam int ROWS        = FILTER_BITS / ROW_W;
  localparam int ROW_AW      = $clog2(ROWS);

  // Probe count
  localparam int MAX_PROBES  = 16;
  localparam int PROBE_W     = $clog2(MAX_PROBES + 1);

  // Register widths fixed by the programming model
  localparam int CFG_SIZE_W  = 17;
  localparam int CFG_HCNT_W  = 5;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT  = 2'd1;

  localparam logic [CFG_SIZE_W-1:0] FILTER_SIZE_RST = 17'd65536;
  localparam logic [CFG_HCNT_W-1:0] HASH_COUNT_RST  = 5'd7;

  // Operation codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // FNV-1a constants
  localparam logic [31:0] FNV_PRIME   = 32'h0100_0193;
  localparam logic [31:0] SEED_FIRST  = 32'h811C_9DC5;
  localparam logic [31:0] SEED_SECOND = 32'h0100_0193;

  // Key job queue
  localparam int JQ_DEPTH = 2;
  localparam int JQ_AW    = $clog2(JQ_DEPTH);

  // Divide loop runs over a 33-bit dividend
  localparam int DIV_STEPS = 33;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic        op;
    logic [31:0] h1;
    logic [31:0] h2;
  } job_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [PROBE_W-1:0] probes;
  } cfg_t;

  typedef struct packed {
    logic clearing;
    logic done;
  } bk_stat_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MOD,
    BK_PREP,
    BK_READ,
    BK_UPDATE,
    BK_DONE
  } bk_state_t;

endpackage

[sv/bfdh_front.sv]
// Front end: hashes key bytes with two FNV-1a chains and emits a job per key.
// Depends on bfdh_pkg.
module bfdh_front
  import bfdh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_operation,
  input  logic [7:0] in_key_byte,
  input  logic       in_last_byte,
  input  logic       hold,
  input  logic       jq_full,
  output logic       in_full,
  output logic       jq_push,
  output job_t       jq_din
);

  logic [31:0] h1_r, h1_nxt;
  logic [31:0] h2_r, h2_nxt;
  logic [31:0] h1_step, h2_step;
  logic        take;

  assign in_full = hold || jq_full;
  assign take    = in_push && !in_full;

  assign h1_step = (h1_r ^ {24'd0, in_key_byte}) * FNV_PRIME;
  assign h2_step = (h2_r ^ {24'd0, in_key_byte}) * FNV_PRIME;

  always_comb begin
    h1_nxt     = h1_r;
    h2_nxt     = h2_r;
    jq_push    = 1'b0;
    jq_din.op  = in_operation;
    jq_din.h1  = h1_step;
    jq_din.h2  = h2_step;
    if (take) begin
      if (in_last_byte) begin
        // hand the finished key on and reload the seeds
        jq_push = 1'b1;
        h1_nxt  = SEED_FIRST;
        h2_nxt  = SEED_SECOND;
      end else begin
        h1_nxt  = h1_step;
        h2_nxt  = h2_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r <= SEED_FIRST;
      h2_r <= SEED_SECOND;
    end else begin
      h1_r <= h1_nxt;
      h2_r <= h2_nxt;
    end
  end

endmodule

[sv/bfdh_job_q.sv]
// Short queue of finished-key jobs between the hashing front and the probe back.
// Depends on bfdh_pkg.
module bfdh_job_q
  import bfdh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  job_t             slot_r [JQ_DEPTH];
  logic [JQ_AW-1:0] wp_r, wp_nxt;
  logic [JQ_AW-1:0] rp_r, rp_nxt;
  logic [JQ_AW:0]   cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (JQ_AW+1)'(JQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == JQ_AW'(JQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == JQ_AW'(JQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= din;
    end
  end

endmodule

[sv/bfdh_back.sv]
// Back end: reduces the hashes modulo the filter size, walks the probes over
// the bit store and holds the result word. Depends on bfdh_pkg.
module bfdh_back
  import bfdh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     jq_empty,
  input  job_t     jq_dout,
  output logic     jq_pop,
  input  logic     out_pop,
  output logic     out_empty,
  output logic     out_was_check,
  output logic     out_maybe_present,
  output bk_stat_t stat
);

  bk_state_t          st_r, st_nxt;
  logic [ROW_AW-1:0]  clr_r, clr_nxt;
  logic [DIV_CW-1:0]  cnt_r, cnt_nxt;
  logic [PROBE_W-1:0] pc_r, pc_nxt;
  logic               op_r, op_nxt;
  logic [32:0]        dva_r, dva_nxt;
  logic [32:0]        dvb_r, dvb_nxt;
  logic [31:0]        s_r, s_nxt;
  logic [31:0]        h2_r, h2_nxt;
  logic [SIZE_W-1:0]  ra_r, ra_nxt;   // h1 mod size, then running probe index
  logic [SIZE_W-1:0]  rb_r, rb_nxt;   // h2 mod size
  logic [SIZE_W-1:0]  rc_r, rc_nxt;   // 2^32 mod size, then (h2 - 2^32) mod size
  logic               all_r, all_nxt;
  logic               ov_r, ov_nxt;
  logic               ow_r, ow_nxt;
  logic               om_r, om_nxt;

  logic [ROW_W-1:0]   mem [ROWS];
  logic [ROW_W-1:0]   rdata_r;
  logic               mem_we;
  logic [ROW_AW-1:0]  mem_addr;
  logic [ROW_W-1:0]   mem_wdata;

  logic [32:0]        sum;
  logic [SIZE_W:0]    adv;
  logic [SIZE_W:0]    dw;
  logic               bit_hit;
  logic               slot_free;

  function automatic logic [SIZE_W-1:0] mod_step(input logic [SIZE_W-1:0] rem,
                                                 input logic b,
                                                 input logic [SIZE_W-1:0] m);
    logic [SIZE_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[SIZE_W-1:0];
  endfunction

  assign out_empty         = !ov_r;
  assign out_was_check     = ow_r;
  assign out_maybe_present = om_r;
  assign slot_free         = !ov_r || out_pop;

  assign stat.clearing = (st_r == BK_CLEAR);
  assign stat.done     = (st_r == BK_DONE) && slot_free;

  // running sum of the probe hashes, carry marks a wrap past 2^32
  assign sum     = {1'b0, s_r} + {1'b0, h2_r};
  assign adv     = {1'b0, ra_r} + {1'b0, (sum[32] ? rc_r : rb_r)};
  assign dw      = {1'b0, rb_r} - {1'b0, rc_r};
  assign bit_hit = rdata_r[ra_r[ROW_BITS-1:0]];

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = ra_r[IDX_W-1:ROW_BITS];
    mem_wdata = rdata_r | (ROW_W'(1) << ra_r[ROW_BITS-1:0]);
    if (st_r == BK_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_r;
      mem_wdata = '0;
    end else if (st_r == BK_UPDATE && op_r == OP_ADD) begin
      mem_we    = 1'b1;
    end
  end

  always_comb begin
    st_nxt  = st_r;
    clr_nxt = clr_r;
    cnt_nxt = cnt_r;
    pc_nxt  = pc_r;
    op_nxt  = op_r;
    dva_nxt = dva_r;
    dvb_nxt = dvb_r;
    s_nxt   = s_r;
    h2_nxt  = h2_r;
    ra_nxt  = ra_r;
    rb_nxt  = rb_r;
    rc_nxt  = rc_r;
    all_nxt = all_r;
    ow_nxt  = ow_r;
    om_nxt  = om_r;
    ov_nxt  = ov_r && !out_pop;
    jq_pop  = 1'b0;

    case (st_r)
      BK_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          st_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!jq_empty) begin
          jq_pop  = 1'b1;
          op_nxt  = jq_dout.op;
          dva_nxt = {1'b0, jq_dout.h1};
          dvb_nxt = {1'b0, jq_dout.h2};
          s_nxt   = jq_dout.h1;
          h2_nxt  = jq_dout.h2;
          ra_nxt  = '0;
          rb_nxt  = '0;
          rc_nxt  = '0;
          cnt_nxt = DIV_CW'(DIV_STEPS - 1);
          all_nxt = 1'b1;
          st_nxt  = BK_MOD;
        end
      end
      BK_MOD: begin
        // one quotient bit per cycle in each of the three lanes
        ra_nxt  = mod_step(ra_r, dva_r[32], cfg.size);
        rb_nxt  = mod_step(rb_r, dvb_r[32], cfg.size);
        rc_nxt  = mod_step(rc_r, (cnt_r == DIV_CW'(DIV_STEPS - 1)), cfg.size);
        dva_nxt = {dva_r[31:0], 1'b0};
        dvb_nxt = {dvb_r[31:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          st_nxt = BK_PREP;
        end
      end
      BK_PREP: begin
        // step used after a wrap: (h2 - 2^32) mod size
        rc_nxt = dw[SIZE_W] ? SIZE_W'(dw + {1'b0, cfg.size}) : dw[SIZE_W-1:0];
        pc_nxt = cfg.probes;
        st_nxt = (cfg.probes == '0) ? BK_DONE : BK_READ;
      end
      BK_READ: begin
        st_nxt = BK_UPDATE;
      end
      BK_UPDATE: begin
        if (op_r == OP_CHECK && !bit_hit) begin
          all_nxt = 1'b0;
        end
        s_nxt  = sum[31:0];
        ra_nxt = (adv >= {1'b0, cfg.size}) ? SIZE_W'(adv - {1'b0, cfg.size})
                                           : adv[SIZE_W-1:0];
        pc_nxt = pc_r - 1'b1;
        st_nxt = (pc_r == PROBE_W'(1)) ? BK_DONE : BK_READ;
      end
      BK_DONE: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          ow_nxt = op_r;
          om_nxt = (op_r == OP_ADD) ? 1'b1 : all_r;
          st_nxt = BK_IDLE;
        end
      end
      default: begin
        st_nxt = BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= BK_CLEAR;
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    pc_r  <= pc_nxt;
    op_r  <= op_nxt;
    dva_r <= dva_nxt;
    dvb_r <= dvb_nxt;
    s_r   <= s_nxt;
    h2_r  <= h2_nxt;
    ra_r  <= ra_nxt;
    rb_r  <= rb_nxt;
    rc_r  <= rc_nxt;
    all_r <= all_nxt;
    ow_r  <= ow_nxt;
    om_r  <= om_nxt;
  end

  // bit store: one row port, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

endmodule

[sv/bloom_filter_fnv_double_hash.sv]
// Bloom filter with FNV-1a double hashing. Throughput: one byte a cycle while
// in_full is low; the back end works on one key at a time, paced by its 33-step
// modulo loop and the row read (READ) and update (UPDATE) of each probe.
// Reset (synchronous, rst_n low) reloads seeds and registers, then a clearing
// pass zeroes all 2048 rows of the bit store while in_full holds high.
module bloom_filter_fnv_double_hash
  import bfdh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // key byte channel
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_operation,
  input  logic [7:0]            in_key_byte,
  input  logic                  in_last_byte,
  // result channel
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_was_check,
  output logic                  out_maybe_present,
  // register writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CFG_SIZE_W-1:0] fsize_r, fsize_nxt;
  logic [CFG_HCNT_W-1:0] hcnt_r, hcnt_nxt;
  cfg_t                  cfg;
  bk_stat_t              bk_stat;

  logic jq_push, jq_full, jq_pop, jq_empty;
  job_t jq_din, jq_dout;

  // Register file: drop writes to unknown indexes
  always_comb begin
    fsize_nxt = fsize_r;
    hcnt_nxt  = hcnt_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FILTER_SIZE: fsize_nxt = cfg_wdata[CFG_SIZE_W-1:0];
        CFG_HASH_COUNT:  hcnt_nxt  = cfg_wdata[CFG_HCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsize_r <= FILTER_SIZE_RST;
      hcnt_r  <= HASH_COUNT_RST;
    end else begin
      fsize_r <= fsize_nxt;
      hcnt_r  <= hcnt_nxt;
    end
  end

  // Clamp the registers to what the store supports: a zero size acts as one
  // bit, oversize values saturate, as does an oversize probe count.
  always_comb begin
    if (fsize_r == '0) begin
      cfg.size = SIZE_W'(1);
    end else if (32'(fsize_r) > 32'(FILTER_BITS)) begin
      cfg.size = SIZE_W'(FILTER_BITS);
    end else begin
      cfg.size = SIZE_W'(fsize_r);
    end
    if (32'(hcnt_r) > 32'(MAX_PROBES)) begin
      cfg.probes = PROBE_W'(MAX_PROBES);
    end else begin
      cfg.probes = PROBE_W'(hcnt_r);
    end
  end

  // Front: hash bytes, hand each finished key to the queue
  bfdh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_operation (in_operation),
    .in_key_byte  (in_key_byte),
    .in_last_byte (in_last_byte),
    .hold         (bk_stat.clearing),
    .jq_full      (jq_full),
    .in_full      (in_full),
    .jq_push      (jq_push),
    .jq_din       (jq_din)
  );

  // Queue decouples hashing from probing
  bfdh_job_q u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (jq_push),
    .din   (jq_din),
    .full  (jq_full),
    .pop   (jq_pop),
    .dout  (jq_dout),
    .empty (jq_empty)
  );

  // Back: modulo, probe walk over the bit store, result word register
  bfdh_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .jq_empty          (jq_empty),
    .jq_dout           (jq_dout),
    .jq_pop            (jq_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_was_check     (out_was_check),
    .out_maybe_present (out_maybe_present),
    .stat              (bk_stat)
  );

`ifndef SYNTHESIS
  // No byte may slip in while the store is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.clearing |-> in_full)
    else $error("input taken during clearing pass");

  // A result word only appears when the back end finishes a key
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(bk_stat.done))
    else $error("result word without a finished key");

  // Leaving reset, the result side is empty
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> out_empty)
    else $error("result pending after reset");

  // An add always acknowledges as present
  a_add_present: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_was_check == OP_ADD) |-> out_maybe_present)
    else $error("add reported absent");
`endif

endmodule

[bench/bfdh_checker.sv]
// Scoreboard for the FNV double-hash Bloom filter: mirrors hashes, registers and bit store,
// predicts each result word and compares it with what the block pops out.
// Depends on bfdh_pkg for sizes, register indexes, operation codes and FNV constants.
module bfdh_checker
  import bfdh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic                  in_operation,
  input  logic [7:0]            in_key_byte,
  input  logic                  in_last_byte,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  logic                  out_was_check,
  input  logic                  out_maybe_present,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    backlog,
  output int                    mismatches
);

  typedef struct packed {
    logic was_check;
    logic maybe_present;
  } verdict_t;

  logic [CFG_SIZE_W-1:0] size_reg;
  logic [CFG_HCNT_W-1:0] probes_reg;
  logic [31:0]           key_hash;
  logic [31:0]           key_stride;
  logic                  bit_map [FILTER_BITS];
  verdict_t              verdict_q [$];

  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
    return (h ^ {24'd0, b}) * FNV_PRIME;
  endfunction

  // Walk the probe sequence of a finished key: set bits on add, test them on check.
  function automatic logic probe_key(input logic op, input logic [31:0] ha,
                                     input logic [31:0] hb);
    logic [31:0] modulus;
    logic [31:0] spot;
    int          probes;
    logic        hit;
    if (size_reg == '0) modulus = 32'd1;
    else if (size_reg > FILTER_BITS) modulus = 32'(FILTER_BITS);
    else modulus = 32'(size_reg);
    probes = (probes_reg > MAX_PROBES) ? MAX_PROBES : int'(probes_reg);
    hit = 1'b1;
    for (int k = 0; k < probes; k++) begin
      spot = (ha + hb * 32'(k)) % modulus;
      if (op == OP_ADD) bit_map[spot] = 1'b1;
      else if (!bit_map[spot]) hit = 1'b0;
    end
    return (op == OP_ADD) ? 1'b1 : hit;
  endfunction

  function automatic void flag(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endfunction

  // Sample on the falling edge ahead of the rising edge that completes each handshake.
  always @(negedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      size_reg   = FILTER_SIZE_RST;
      probes_reg = HASH_COUNT_RST;
      key_hash   = SEED_FIRST;
      key_stride = SEED_SECOND;
      mismatches = 0;
      foreach (bit_map[i]) bit_map[i] = 1'b0;
      verdict_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (verdict_q.size() == 0) begin
          flag($sformatf("unexpected result word: was_check=%b maybe_present=%b",
                         out_was_check, out_maybe_present));
        end else begin
          want = verdict_q.pop_front();
          if (out_was_check !== want.was_check || out_maybe_present !== want.maybe_present)
            flag($sformatf("result mismatch: expected was_check=%b maybe_present=%b, got %b %b",
                           want.was_check, want.maybe_present,
                           out_was_check, out_maybe_present));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FILTER_SIZE: size_reg = cfg_wdata[CFG_SIZE_W-1:0];
          CFG_HASH_COUNT:  probes_reg = cfg_wdata[CFG_HCNT_W-1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        key_hash   = fnv_mix(key_hash, in_key_byte);
        key_stride = fnv_mix(key_stride, in_key_byte);
        if (in_last_byte) begin
          want.was_check     = (in_operation == OP_CHECK);
          want.maybe_present = probe_key(in_operation, key_hash, key_stride);
          verdict_q.push_back(want);
          key_hash   = SEED_FIRST;
          key_stride = SEED_SECOND;
        end
      end
    end
    backlog = verdict_q.size();
  end

endmodule

[bench/bloom_filter_fnv_double_hash_test.sv]
// Top of the Bloom filter bench: clock, reset, key traffic, register programming and verdict.
// Depends on bfdh_pkg, the bloom_filter_fnv_double_hash block and the bfdh_checker scoreboard.
module bloom_filter_fnv_double_hash_test;
  import bfdh_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 8;
  localparam int PHASES          = 8;
  localparam int PHASE_WORDS     = 115;
  // Margin for the back end to run dry after the last result word; round up generously.
  localparam int DRAIN_CYCLES    = 100;
  localparam int HOLD_OFF_CYCLES = 600;
  // Covers the clearing pass and the long receiver hold-off several times over.
  localparam int STALL_LIMIT     = 20000;
  localparam int BANK_KEYS       = 48;
  localparam int MAX_KEY_LEN     = 16;

  // Register indexes that decode to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic                  in_operation = OP_ADD;
  logic [7:0]            in_key_byte = 8'd0;
  logic                  in_last_byte = 1'b0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic                  out_was_check;
  logic                  out_maybe_present;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FILTER_SIZE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int    backlog;
  int    mismatches;
  int    words_sent = 0;
  int    quiet_cycles = 0;
  pace_t pace = PACE_FREE;
  logic  hold_off = 1'b0;

  // Key under construction, and keys already added so that checks can hit them
  logic [7:0] key_buf [MAX_KEY_LEN];
  logic [7:0] bank [BANK_KEYS][MAX_KEY_LEN];
  int         bank_len [BANK_KEYS];
  int         bank_count = 0;
  int         bank_next = 0;

  // Register settings per random phase: extremes, saturating values and junk upper bits
  logic [CFG_DATA_W-1:0] size_plan [PHASES] = '{17'd65536, 17'd1, 17'd0, 17'h1FFFF,
                                                17'd997, 17'd8, 17'd65535, 17'd4096};
  logic [CFG_DATA_W-1:0] hash_plan [PHASES] = '{17'd16, 17'd1, 17'h1FFFF, 17'd0,
                                                17'd5, 17'h0AAA3, 17'd17, 17'd7};
  pace_t                 pace_plan [PHASES] = '{PACE_FREE, PACE_SEND_GAPS, PACE_RECV_STALLS,
                                                PACE_BOTH, PACE_FREE, PACE_SEND_GAPS,
                                                PACE_RECV_STALLS, PACE_BOTH};

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  bloom_filter_fnv_double_hash dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_operation      (in_operation),
    .in_key_byte       (in_key_byte),
    .in_last_byte      (in_last_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_was_check     (out_was_check),
    .out_maybe_present (out_maybe_present),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  bfdh_checker watch (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_operation      (in_operation),
    .in_key_byte       (in_key_byte),
    .in_last_byte      (in_last_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_was_check     (out_was_check),
    .out_maybe_present (out_maybe_present),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .backlog           (backlog),
    .mismatches        (mismatches)
  );

  function automatic bit send_gap();
    case (pace)
      PACE_SEND_GAPS: return $urandom_range(0, 99) < 45;
      PACE_BOTH:      return $urandom_range(0, 99) < 23;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic bit recv_stall();
    case (pace)
      PACE_RECV_STALLS: return $urandom_range(0, 99) < 45;
      PACE_BOTH:        return $urandom_range(0, 99) < 23;
      default:          return 1'b0;
    endcase
  endfunction

  // Lean on the byte extremes now and then so both ends of the range turn up often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Fill key_buf with a fresh key; mostly short, sometimes up to the given length.
  function automatic int fresh_key(input int longest);
    int len;
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(5, longest);
    for (int k = 0; k < len; k++) key_buf[k] = pick_byte();
    return len;
  endfunction

  function automatic void keep_key(input int len);
    for (int k = 0; k < len; k++) bank[bank_next][k] = key_buf[k];
    bank_len[bank_next] = len;
    bank_next = (bank_next + 1) % BANK_KEYS;
    if (bank_count < BANK_KEYS) bank_count++;
  endfunction

  function automatic int recall_key();
    int slot;
    slot = $urandom_range(0, bank_count - 1);
    for (int k = 0; k < bank_len[slot]; k++) key_buf[k] = bank[slot][k];
    return bank_len[slot];
  endfunction

  // Offer one key byte and hold it until the block takes it. Entered and left on a rising
  // edge; in_push stays high on return so a following word can go out without a gap.
  task automatic send_byte(input logic op, input logic [7:0] b, input logic last);
    logic took;
    while (send_gap()) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_operation <= op;
    in_key_byte  <= b;
    in_last_byte <= last;
    do begin
      @(negedge clk);
      took = !in_full;
      @(posedge clk);
    end while (!took);
    words_sent++;
  endtask

  // Send key_buf as one key. Earlier bytes carry the opposite operation, which the block
  // must ignore since only the last byte's operation counts.
  task automatic send_key(input logic op, input int len);
    for (int k = 0; k < len; k++) begin
      if (k == len - 1) send_byte(op, key_buf[k], 1'b1);
      else send_byte(~op, key_buf[k], 1'b0);
    end
  endtask

  // Drop push, wait for every outstanding result word, then let the back end run dry.
  task automatic settle();
    in_push <= 1'b0;
    while (backlog != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly adds and checks of known or fresh keys; a small share of long keys with a
  // random operation stands in for noise.
  task automatic random_traffic(input int words);
    int stop;
    int len;
    int pick;
    stop = words_sent + words;
    while (words_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 || bank_count == 0) begin
        len = fresh_key(6);
        send_key(OP_ADD, len);
        keep_key(len);
      end else if (pick < 75) begin
        len = recall_key();
        send_key(OP_CHECK, len);
      end else if (pick < 92) begin
        len = fresh_key(6);
        send_key(OP_CHECK, len);
      end else begin
        len = fresh_key(MAX_KEY_LEN);
        send_key(($urandom_range(0, 1) != 0) ? OP_CHECK : OP_ADD, len);
      end
    end
  endtask

  // Receiver: pop at random according to the pace, or hold off for a long stretch on request
  // so the block backs up and stalls the key channel.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_pop  <= 1'b0;
        hold_off <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_pop <= !recv_stall();
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  always @(negedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, on the reset register values first: byte extremes, both operations,
    // a check of a stored key and of a missing one, and ignored operations on early bytes.
    key_buf[0] = 8'h00;
    send_key(OP_ADD, 1);
    send_key(OP_CHECK, 1);
    key_buf[0] = 8'hFF;
    send_key(OP_CHECK, 1);
    key_buf[0] = 8'hFF;
    key_buf[1] = 8'h80;
    key_buf[2] = 8'h7F;
    send_key(OP_ADD, 3);
    send_key(OP_CHECK, 3);
    send_key(OP_CHECK, 2);

    // Change the probe count in the middle of a key: the new value rules at its last byte.
    send_byte(OP_CHECK, 8'hA5, 1'b0);
    settle();
    write_reg(CFG_HASH_COUNT, 17'd16);
    send_byte(OP_ADD, 8'h5A, 1'b1);
    key_buf[0] = 8'hA5;
    key_buf[1] = 8'h5A;
    send_key(OP_CHECK, 2);

    // Zero filter size folds every probe onto bit zero; an oversized probe count saturates.
    settle();
    write_reg(CFG_FILTER_SIZE, 17'd0);
    write_reg(CFG_HASH_COUNT, 17'd31);
    key_buf[0] = 8'h11;
    send_key(OP_ADD, 1);
    key_buf[0] = 8'h22;
    send_key(OP_CHECK, 1);

    // Oversized filter size saturates; with no probes a check always says maybe.
    settle();
    write_reg(CFG_FILTER_SIZE, 17'h1FFFF);
    write_reg(CFG_HASH_COUNT, 17'd0);
    key_buf[0] = 8'h33;
    send_key(OP_CHECK, 1);
    key_buf[0] = 8'h44;
    send_key(OP_ADD, 1);

    // Writes to indexes that decode to nothing must leave both registers alone.
    settle();
    write_reg(CFG_SPARE_LO, 17'h1FFFF);
    write_reg(CFG_SPARE_HI, 17'h00000);
    key_buf[0] = 8'h55;
    send_key(OP_CHECK, 1);

    // Single-bit filter with a single probe.
    settle();
    write_reg(CFG_FILTER_SIZE, 17'd1);
    write_reg(CFG_HASH_COUNT, 17'd1);
    key_buf[0] = 8'h66;
    send_key(OP_CHECK, 1);

    // Random phases: reprogram while idle, then run traffic at the phase's pace. Each
    // boundary also makes the sender pause until every result word is back.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(CFG_FILTER_SIZE, size_plan[p]);
      write_reg(CFG_HASH_COUNT, hash_plan[p]);
      if (p == PHASES - 1) write_reg(CFG_SPARE_HI, 17'($urandom()));
      pace <= pace_plan[p];
      if (p == 0) hold_off <= 1'b1;
      random_traffic(PHASE_WORDS);
    end

    settle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
